// ===== hw/rtl/palette_remap_nearest_scaler_assert.svh =====
// Assertion macros for the palette remap scaler.
// Expects clk and rst_n in the scope of each use.
`ifndef PALETTE_REMAP_NEAREST_SCALER_ASSERT_SVH
`define PALETTE_REMAP_NEAREST_SCALER_ASSERT_SVH

// same-cycle implication
`define PRNS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prns assertion failed");

// next-cycle implication
`define PRNS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prns assertion failed");

`endif

// ===== hw/rtl/prns_pkg.sv =====
// Shared types, constants and helpers of the palette remap scaler.
// No dependencies.
package prns_pkg;

    localparam int SKIN_BYTES  = 262144;
    localparam int SKIN_AW     = 18;
    localparam int TRANS_BYTES = 16384;
    localparam int TRANS_AW    = 14;
    localparam int TA_W        = 15;
    localparam int PAL_DEPTH   = 256;
    localparam int OUT_MAX_W   = 512;
    localparam int OUT_MAX_H   = 256;
    localparam int OW_W        = 10;
    localparam int OH_W        = 9;
    localparam int STEP_W      = 26;
    localparam int STEP_CNT_W  = 5;
    localparam int FRAC_W      = 27;
    localparam int SX_W        = 11;
    localparam int PROD_W      = 18;
    localparam int DIV_N       = 18;
    localparam int SY_W        = 10;
    localparam int SA_W        = 21;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;
    localparam int APB_AW      = 5;

    localparam logic [1:0] MODE_PAL   = 2'd0;
    localparam logic [1:0] MODE_TRANS = 2'd1;
    localparam logic [1:0] MODE_SKIN  = 2'd2;
    localparam logic [1:0] MODE_FETCH = 2'd3;

    localparam logic [2:0] REG_MAX_SIZE = 3'd0;
    localparam logic [2:0] REG_MIP      = 3'd1;
    localparam logic [2:0] REG_SRC_W    = 3'd2;
    localparam logic [2:0] REG_SRC_H    = 3'd3;
    localparam logic [2:0] REG_TOP      = 3'd4;
    localparam logic [2:0] REG_BOTTOM   = 3'd5;
    localparam logic [2:0] REG_CLASS    = 3'd6;

    localparam logic [7:0] MASK_KEEP = 8'd255;
    localparam logic [3:0] COLOR_MAX = 4'd10;

    typedef struct packed {
        logic [OW_W-1:0]   ow;
        logic [OH_W-1:0]   oh;
        logic [STEP_W-1:0] step;
        logic [9:0]        src_width;
        logic [9:0]        src_height;
        logic [3:0]        top_color;
        logic [3:0]        bottom_color;
        logic [2:0]        player_class;
        logic              bad;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [17:0] address;
        logic [31:0] data;
        logic [8:0]  column;
        logic [7:0]  row;
        logic        bad;
        logic        zero;
    } item_t;

    typedef struct packed {
        logic [1:0]      mode;
        logic [17:0]     address;
        logic [31:0]     data;
        logic [SX_W-1:0] sx;
        logic            bad;
        logic            zero;
    } bk_t;

    function automatic logic [TA_W-1:0] class_offset(input logic [2:0] cls);
        logic [TA_W-1:0] off;
        case (cls)
            3'd2:    off = TA_W'(0);
            3'd3:    off = TA_W'(1 * 14 * 256);
            default: off = TA_W'(2 * 14 * 256);
        endcase
        return off;
    endfunction

endpackage

// ===== hw/rtl/prns_in_if.sv =====
// Input item channel of the palette remap scaler.
// No dependencies.
interface prns_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [17:0] address;
    logic [31:0] data;
    logic [8:0]  column;
    logic [7:0]  row;

    modport source (output valid, mode, address, data, column, row, input ready);
    modport sink (input valid, mode, address, data, column, row, output ready);
endinterface

// ===== hw/rtl/prns_out_if.sv =====
// Result item channel of the palette remap scaler.
// No dependencies.
interface prns_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_rgba;
    logic        bad_size;

    modport source (output valid, pixel_rgba, bad_size, input ready);
    modport sink (input valid, pixel_rgba, bad_size, output ready);
endinterface

// ===== hw/rtl/palette_remap_nearest_scaler.sv =====
// Stages: queue, stage 0, 18 division stages, 5 more to the output register.
// Throughput: one item per cycle when not stalled by item_out or the step division;
// loads and fetches share the in-order back-end pipeline. After reset and every register
// write, input is held off while the horizontal step is divided out one bit per cycle.
// Reset clears control state only; palette, translation and source stores are not cleared.
// Top level: APB config, front end, item queue, back end. Depends on prns_pkg, interfaces.
module palette_remap_nearest_scaler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prns_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    prns_in_if.sink                     item_in,
    prns_out_if.source                  item_out
);

    prns_pkg::cfg_t  cfg;
    prns_pkg::item_t q_wdata;
    prns_pkg::item_t q_rdata;
    logic            busy;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    prns_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .busy    (busy)
    );

    prns_front u_front (
        .cfg     (cfg),
        .busy    (busy),
        .q_full  (q_full),
        .item_in (item_in),
        .push    (push),
        .entry   (q_wdata)
    );

    prns_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    prns_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (q_rdata),
        .q_empty  (q_empty),
        .pop      (pop),
        .item_out (item_out)
    );

endmodule

// ===== hw/rtl/prns_cfg.sv =====
// APB register file and output-size / horizontal step derivation.
// Depends on prns_pkg; step comes from a restoring division.
module prns_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [prns_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output prns_pkg::cfg_t            cfg,
    output logic                      busy
);

    logic [12:0] max_size_reg;
    logic [3:0]  mip_reg;
    logic [9:0]  sw_reg;
    logic [9:0]  sh_reg;
    logic [3:0]  top_reg;
    logic [3:0]  bot_reg;
    logic [2:0]  cls_reg;
    logic        start_reg;
    logic        busy_reg;
    logic [prns_pkg::STEP_W-1:0]     dvd_reg;
    logic [prns_pkg::OW_W-1:0]       rem_reg;
    logic [prns_pkg::STEP_W-1:0]     quo_reg;
    logic [prns_pkg::STEP_CNT_W-1:0] cnt_reg;

    logic [2:0]                   idx;
    logic                         wr;
    logic [prns_pkg::OW_W-1:0]    base_w;
    logic [prns_pkg::OH_W-1:0]    base_h;
    logic [prns_pkg::OW_W-1:0]    ow;
    logic [prns_pkg::OH_W-1:0]    oh;
    logic [3:0]                   lowprod;
    logic [prns_pkg::OW_W:0]      rem_sh;
    logic                         ge;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= '0;
            mip_reg      <= '0;
            sw_reg       <= 10'd1;
            sh_reg       <= 10'd1;
            top_reg      <= '0;
            bot_reg      <= '0;
            cls_reg      <= 3'd1;
            start_reg    <= 1'b1;
        end
        else
        begin
            start_reg <= wr;
            if (wr)
            begin
                case (idx)
                    prns_pkg::REG_MAX_SIZE: max_size_reg <= pwdata[12:0];
                    prns_pkg::REG_MIP:      mip_reg      <= pwdata[3:0];
                    prns_pkg::REG_SRC_W:    sw_reg       <= pwdata[9:0];
                    prns_pkg::REG_SRC_H:    sh_reg       <= pwdata[9:0];
                    prns_pkg::REG_TOP:      top_reg      <= pwdata[3:0];
                    prns_pkg::REG_BOTTOM:   bot_reg      <= pwdata[3:0];
                    prns_pkg::REG_CLASS:    cls_reg      <= pwdata[2:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            prns_pkg::REG_MAX_SIZE: prdata = 32'(max_size_reg);
            prns_pkg::REG_MIP:      prdata = 32'(mip_reg);
            prns_pkg::REG_SRC_W:    prdata = 32'(sw_reg);
            prns_pkg::REG_SRC_H:    prdata = 32'(sh_reg);
            prns_pkg::REG_TOP:      prdata = 32'(top_reg);
            prns_pkg::REG_BOTTOM:   prdata = 32'(bot_reg);
            prns_pkg::REG_CLASS:    prdata = 32'(cls_reg);
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        if (max_size_reg == '0)
        begin
            base_w = prns_pkg::OW_W'(prns_pkg::OUT_MAX_W);
            base_h = prns_pkg::OH_W'(prns_pkg::OUT_MAX_H);
        end
        else
        begin
            base_w = (max_size_reg < 13'(prns_pkg::OUT_MAX_W))
                   ? max_size_reg[prns_pkg::OW_W-1:0] : prns_pkg::OW_W'(prns_pkg::OUT_MAX_W);
            base_h = (max_size_reg < 13'(prns_pkg::OUT_MAX_H))
                   ? max_size_reg[prns_pkg::OH_W-1:0] : prns_pkg::OH_W'(prns_pkg::OUT_MAX_H);
        end
        ow      = base_w >> mip_reg;
        oh      = base_h >> mip_reg;
        lowprod = sw_reg[1:0] * sh_reg[1:0];
    end

    // restoring division (src_width << 16) / ow, one quotient bit per cycle
    assign rem_sh = {rem_reg, dvd_reg[prns_pkg::STEP_W-1]};
    assign ge     = rem_sh >= {1'b0, ow};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start_reg)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == prns_pkg::STEP_CNT_W'(prns_pkg::STEP_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_reg)
        begin
            dvd_reg <= {sw_reg, 16'd0};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? prns_pkg::OW_W'(rem_sh - {1'b0, ow}) : rem_sh[prns_pkg::OW_W-1:0];
            quo_reg <= {quo_reg[prns_pkg::STEP_W-2:0], ge};
            dvd_reg <= {dvd_reg[prns_pkg::STEP_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg || start_reg;

    always_comb
    begin
        cfg.ow           = ow;
        cfg.oh           = oh;
        cfg.step         = quo_reg;
        cfg.src_width    = sw_reg;
        cfg.src_height   = sh_reg;
        cfg.top_color    = top_reg;
        cfg.bottom_color = bot_reg;
        cfg.player_class = cls_reg;
        cfg.bad          = (lowprod[1:0] != 2'd0) || (ow == '0) || (oh == '0);
    end

endmodule

// ===== hw/rtl/prns_front.sv =====
// Front end: accepts items, clamps fetch coordinates and flags size errors.
// Depends on prns_pkg and prns_in_if.
module prns_front (
    input  prns_pkg::cfg_t   cfg,
    input  logic             busy,
    input  logic             q_full,
    prns_in_if.sink          item_in,
    output logic             push,
    output prns_pkg::item_t  entry
);

    assign item_in.ready = !busy && !q_full;
    assign push          = item_in.valid && item_in.ready;

    always_comb
    begin
        entry.mode    = item_in.mode;
        entry.address = item_in.address;
        entry.data    = item_in.data;
        entry.column  = ({1'b0, item_in.column} >= cfg.ow)
                      ? 9'(cfg.ow - 1'b1) : item_in.column;
        entry.row     = ({1'b0, item_in.row} >= cfg.oh)
                      ? 8'(cfg.oh - 1'b1) : item_in.row;
        entry.bad     = cfg.bad;
        entry.zero    = (cfg.ow == '0) || (cfg.oh == '0);
    end

endmodule

// ===== hw/rtl/prns_queue.sv =====
// Four-entry item queue between front end and back end.
// Depends on prns_pkg and the assertion header.
`include "palette_remap_nearest_scaler_assert.svh"
module prns_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  prns_pkg::item_t  wdata,
    output logic             full,
    input  logic             pop,
    output prns_pkg::item_t  rdata,
    output logic             empty
);

    prns_pkg::item_t           q_reg [prns_pkg::Q_DEPTH];
    logic [prns_pkg::Q_AW-1:0] wr_ptr_reg;
    logic [prns_pkg::Q_AW-1:0] rd_ptr_reg;
    logic [prns_pkg::Q_AW:0]   count_reg;

    assign full  = count_reg == (prns_pkg::Q_AW + 1)'(prns_pkg::Q_DEPTH);
    assign empty = count_reg == '0;
    assign rdata = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= wdata;
        end
    end

    `PRNS_ASSERT_NOW(a_no_push_full, full, !push)
    `PRNS_ASSERT_NOW(a_no_pop_empty, empty, !pop)
    `PRNS_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hw/rtl/prns_back.sv =====
// Back end: scaling math, pipelined row division, store writes and lookups.
// Depends on prns_pkg and prns_out_if.
module prns_back (
    input  logic             clk,
    input  logic             rst_n,
    input  prns_pkg::cfg_t   cfg,
    input  prns_pkg::item_t  head,
    input  logic             q_empty,
    output logic             pop,
    prns_out_if.source       item_out
);

    logic adv;

    // stage 0 and row-division stages
    logic                        vld_reg [prns_pkg::DIV_N+1];
    prns_pkg::bk_t               pay_reg [prns_pkg::DIV_N+1];
    logic [prns_pkg::OH_W-1:0]   rem_reg [prns_pkg::DIV_N+1];
    logic [prns_pkg::PROD_W-1:0] quo_reg [prns_pkg::DIV_N+1];
    logic [prns_pkg::PROD_W-1:0] dvd_reg [prns_pkg::DIV_N+1];

    logic [34:0]                 cs;
    logic [prns_pkg::FRAC_W-1:0] frac;
    prns_pkg::bk_t               s0_next;

    // address, skin, translation, palette stages
    logic                        s1_vld_reg;
    prns_pkg::bk_t               s1_reg;
    logic [prns_pkg::SA_W-1:0]   s1_sa_reg;
    logic                        s2_vld_reg;
    prns_pkg::bk_t               s2_reg;
    logic                        s2_inr_reg;
    logic [7:0]                  skin_rd_reg;
    logic                        s3_vld_reg;
    prns_pkg::bk_t               s3_reg;
    logic [7:0]                  idx3_reg;
    logic [7:0]                  tm_reg;
    logic [7:0]                  bm_reg;
    logic [7:0]                  tr_reg;
    logic [7:0]                  br_reg;
    logic [3:0]                  ok_reg;
    logic                        s4_vld_reg;
    prns_pkg::bk_t               s4_reg;
    logic [31:0]                 pal_rd_reg;
    logic                        out_valid_reg;
    logic [31:0]                 pixel_reg;
    logic                        bad_reg;

    logic [7:0]  skin_mem [prns_pkg::SKIN_BYTES];
    logic [7:0]  tra_mem [prns_pkg::TRANS_BYTES];
    logic [7:0]  trb_mem [prns_pkg::TRANS_BYTES];
    logic [31:0] pal_mem [prns_pkg::PAL_DEPTH];

    logic [prns_pkg::SA_W-1:0] sa_next;
    logic [7:0]                idx;
    logic [prns_pkg::TA_W-1:0] off;
    logic [prns_pkg::TA_W-1:0] a_tm;
    logic [prns_pkg::TA_W-1:0] a_bm;
    logic [prns_pkg::TA_W-1:0] a_tr;
    logic [prns_pkg::TA_W-1:0] a_br;
    logic [7:0]                tm;
    logic [7:0]                bm;
    logic [7:0]                t;
    logic                      top_en;
    logic                      bot_en;

    assign adv = !out_valid_reg || item_out.ready;
    assign pop = adv && !q_empty;

    // stage 0: horizontal fixed-point position and row product
    always_comb
    begin
        cs              = 35'(head.column) * 35'(cfg.step);
        frac            = prns_pkg::FRAC_W'(cs) + prns_pkg::FRAC_W'(cfg.step >> 1);
        s0_next.mode    = head.mode;
        s0_next.address = head.address;
        s0_next.data    = head.data;
        s0_next.sx      = frac[prns_pkg::FRAC_W-1:16];
        s0_next.bad     = head.bad;
        s0_next.zero    = head.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg[0] <= s0_next;
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            dvd_reg[0] <= prns_pkg::PROD_W'(head.row) * prns_pkg::PROD_W'(cfg.src_height);
        end
    end

    // row * src_height / oh, one quotient bit per stage
    for (genvar k = 0; k < prns_pkg::DIV_N; k++)
    begin : g_div
        logic [prns_pkg::OH_W:0] rsh;
        logic                    ge;

        assign rsh = {rem_reg[k], dvd_reg[k][prns_pkg::PROD_W-1]};
        assign ge  = rsh >= {1'b0, cfg.oh};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1] <= ge ? prns_pkg::OH_W'(rsh - {1'b0, cfg.oh})
                                   : rsh[prns_pkg::OH_W-1:0];
                quo_reg[k+1] <= {quo_reg[k][prns_pkg::PROD_W-2:0], ge};
                dvd_reg[k+1] <= {dvd_reg[k][prns_pkg::PROD_W-2:0], 1'b0};
                pay_reg[k+1] <= pay_reg[k];
            end
        end
    end

    // source address
    assign sa_next = prns_pkg::SA_W'(cfg.src_width)
                   * prns_pkg::SA_W'(quo_reg[prns_pkg::DIV_N][prns_pkg::SY_W-1:0])
                   + prns_pkg::SA_W'(pay_reg[prns_pkg::DIV_N].sx);

    // translation addresses from the skin index
    always_comb
    begin
        idx    = s2_inr_reg ? skin_rd_reg : 8'd0;
        off    = prns_pkg::class_offset(cfg.player_class);
        a_tm   = prns_pkg::TA_W'(256) + off + prns_pkg::TA_W'(idx);
        a_bm   = prns_pkg::TA_W'(512) + off + prns_pkg::TA_W'(idx);
        a_tr   = prns_pkg::TA_W'(768) + off
               + prns_pkg::TA_W'({cfg.top_color - 1'b1, 8'd0}) + prns_pkg::TA_W'(idx);
        a_br   = prns_pkg::TA_W'(768) + off
               + prns_pkg::TA_W'({cfg.bottom_color - 1'b1, 8'd0}) + prns_pkg::TA_W'(idx);
    end

    // recolor select
    always_comb
    begin
        top_en = cfg.top_color inside {[4'd1 : prns_pkg::COLOR_MAX]};
        bot_en = cfg.bottom_color inside {[4'd1 : prns_pkg::COLOR_MAX]};
        tm     = ok_reg[0] ? tm_reg : 8'd0;
        bm     = ok_reg[1] ? bm_reg : 8'd0;
        t      = idx3_reg;
        if (top_en && tm != prns_pkg::MASK_KEEP)
        begin
            t = ok_reg[2] ? tr_reg : 8'd0;
        end
        if (bot_en && bm != prns_pkg::MASK_KEEP)
        begin
            t = ok_reg[3] ? br_reg : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= vld_reg[prns_pkg::DIV_N];
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            out_valid_reg <= s4_vld_reg && (s4_reg.mode == prns_pkg::MODE_FETCH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= pay_reg[prns_pkg::DIV_N];
            s1_sa_reg  <= sa_next;
            s2_reg     <= s1_reg;
            s2_inr_reg <= s1_sa_reg < prns_pkg::SA_W'(prns_pkg::SKIN_BYTES);
            s3_reg     <= s2_reg;
            idx3_reg   <= idx;
            ok_reg     <= {a_br < prns_pkg::TA_W'(prns_pkg::TRANS_BYTES),
                           a_tr < prns_pkg::TA_W'(prns_pkg::TRANS_BYTES),
                           a_bm < prns_pkg::TA_W'(prns_pkg::TRANS_BYTES),
                           a_tm < prns_pkg::TA_W'(prns_pkg::TRANS_BYTES)};
            s4_reg     <= s3_reg;
            pixel_reg  <= s4_reg.zero ? 32'd0 : pal_rd_reg;
            bad_reg    <= s4_reg.bad;
        end
    end

    // skin store
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s1_vld_reg && s1_reg.mode == prns_pkg::MODE_SKIN)
            begin
                skin_mem[s1_reg.address[prns_pkg::SKIN_AW-1:0]] <= s1_reg.data[7:0];
            end
            skin_rd_reg <= skin_mem[s1_sa_reg[prns_pkg::SKIN_AW-1:0]];
        end
    end

    // translation store, two copies for four reads per item
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s2_vld_reg && s2_reg.mode == prns_pkg::MODE_TRANS
                && s2_reg.address < 18'(prns_pkg::TRANS_BYTES))
            begin
                tra_mem[s2_reg.address[prns_pkg::TRANS_AW-1:0]] <= s2_reg.data[7:0];
                trb_mem[s2_reg.address[prns_pkg::TRANS_AW-1:0]] <= s2_reg.data[7:0];
            end
            tm_reg <= tra_mem[a_tm[prns_pkg::TRANS_AW-1:0]];
            tr_reg <= tra_mem[a_tr[prns_pkg::TRANS_AW-1:0]];
            bm_reg <= trb_mem[a_bm[prns_pkg::TRANS_AW-1:0]];
            br_reg <= trb_mem[a_br[prns_pkg::TRANS_AW-1:0]];
        end
    end

    // palette
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s3_vld_reg && s3_reg.mode == prns_pkg::MODE_PAL
                && s3_reg.address < 18'(prns_pkg::PAL_DEPTH))
            begin
                pal_mem[s3_reg.address[7:0]] <= s3_reg.data;
            end
            pal_rd_reg <= pal_mem[t];
        end
    end

    assign item_out.valid      = out_valid_reg;
    assign item_out.pixel_rgba = pixel_reg;
    assign item_out.bad_size   = bad_reg;

endmodule

// ===== bench/tb_palette_remap_nearest_scaler.sv =====
// Self-checking bench for palette_remap_nearest_scaler: loads the stores, sweeps
// register settings and checks every fetched pixel against an in-bench predictor or table.
// Depends on prns_pkg, prns_in_if, prns_out_if and the RTL top level.
module tb_palette_remap_nearest_scaler;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int TRANS_LO       = 256;
    localparam int TRANS_HI       = 10495;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 80;
    localparam int IDX_MAX        = 7;
    localparam int PAL_LOADED     = 16;
    localparam int TRANS_BLOCKS   = 12;

    typedef struct packed {
        logic [31:0] pixel_rgba;
        logic        bad_size;
    } pixel_t;

    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        logic [1:0]  mode;
        logic [17:0] address;
        logic [31:0] data;
        logic [8:0]  column;
        logic [7:0]  row;
        bit          typed;
        logic [31:0] t_pix;
        logic        t_bad;
    } stim_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [prns_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    prns_in_if  in_ch ();
    prns_out_if out_ch ();

    palette_remap_nearest_scaler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .item_in  (in_ch),
        .item_out (out_ch)
    );

    // shadow registers and stores
    logic [12:0] sh_max;
    logic [3:0]  sh_mip;
    logic [9:0]  sh_w;
    logic [9:0]  sh_h;
    logic [3:0]  sh_top;
    logic [3:0]  sh_bottom;
    logic [2:0]  sh_class;
    logic [31:0] pal_mem [prns_pkg::PAL_DEPTH];
    logic [7:0]  trans_mem [prns_pkg::TRANS_BYTES];
    logic [7:0]  skin_mem [prns_pkg::SKIN_BYTES];
    bit          skin_wr [prns_pkg::SKIN_BYTES];

    pixel_t      expected_pixels [$];
    int          errors;
    int          idle_cycles;
    int          pixels_seen;
    bit          tx_burst;
    bit          rx_burst;
    bit          held;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic logic [14:0] block_offset(input logic [2:0] cls);
        case (cls)
            3'd2:    return 15'd0;
            3'd3:    return 15'(14 * 256);
            default: return 15'(2 * 14 * 256);
        endcase
    endfunction

    // source bytes stay on the few indexes whose translation entries are loaded
    function automatic logic [31:0] skin_word();
        logic [31:0] w;
        w = $urandom;
        w[7:0] = 8'($urandom_range(IDX_MAX));
        return w;
    endfunction

    // translation bytes are either the keep mask or a loaded palette entry
    function automatic logic [31:0] trans_word();
        logic [31:0] w;
        w = $urandom;
        w[7:0] = ($urandom_range(2) == 0) ? prns_pkg::MASK_KEEP
                                          : 8'($urandom_range(PAL_LOADED - 1));
        return w;
    endfunction

    function automatic logic [7:0] recolor(input logic [7:0] idx);
        logic [31:0] off;
        logic [7:0]  t;
        off = 32'(block_offset(sh_class));
        t = idx;
        if (sh_top >= 1 && sh_top <= prns_pkg::COLOR_MAX
                && trans_mem[256 + off + idx] != prns_pkg::MASK_KEEP)
            t = trans_mem[768 + off + (sh_top - 1) * 256 + idx];
        if (sh_bottom >= 1 && sh_bottom <= prns_pkg::COLOR_MAX
                && trans_mem[512 + off + idx] != prns_pkg::MASK_KEEP)
            t = trans_mem[768 + off + (sh_bottom - 1) * 256 + idx];
        return t;
    endfunction

    // ok is cleared when the fetch would read a source byte never written
    function automatic void predict_pixel(input logic [8:0] c_in, input logic [7:0] r_in,
                                          output pixel_t res, output bit ok);
        logic [31:0] ow, oh, col, row, step, frac, sx, sy, sa;
        logic [7:0]  idx;
        ok = 1;
        res.pixel_rgba = '0;
        if (sh_max > 0)
        begin
            ow = (sh_max < prns_pkg::OUT_MAX_W) ? 32'(sh_max) : prns_pkg::OUT_MAX_W;
            oh = (sh_max < prns_pkg::OUT_MAX_H) ? 32'(sh_max) : prns_pkg::OUT_MAX_H;
        end
        else
        begin
            ow = prns_pkg::OUT_MAX_W;
            oh = prns_pkg::OUT_MAX_H;
        end
        ow = ow >> sh_mip;
        oh = oh >> sh_mip;
        res.bad_size = ((32'(sh_w) * 32'(sh_h)) & 3) != 0 || ow == 0 || oh == 0;
        if (ow != 0 && oh != 0)
        begin
            col = (c_in >= ow) ? ow - 1 : 32'(c_in);
            row = (r_in >= oh) ? oh - 1 : 32'(r_in);
            step = (32'(sh_w) * 32'h10000) / ow;
            frac = (step >> 1) + col * step;
            sx = frac >> 16;
            sy = (row * 32'(sh_h)) / oh;
            sa = 32'(sh_w) * sy + sx;
            idx = 8'd0;
            if (sa < prns_pkg::SKIN_BYTES)
            begin
                ok = skin_wr[sa];
                idx = skin_mem[sa];
            end
            res.pixel_rgba = pal_mem[recolor(idx)];
        end
    endfunction

    task automatic send(input logic [1:0] mode, input logic [17:0] addr,
                        input logic [31:0] data, input logic [8:0] col,
                        input logic [7:0] row, input bit typed = 0,
                        input logic [31:0] t_pix = '0, input logic t_bad = 1'b0);
        int     gap;
        bit     rdy;
        bit     ok;
        pixel_t res;
        if ($urandom_range(63) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(15);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.address <= addr;
        in_ch.data    <= data;
        in_ch.column  <= col;
        in_ch.row     <= row;
        do
        begin
            @(negedge clk);
            rdy = in_ch.ready;
            @(posedge clk);
        end while (!rdy);
        case (mode)
            prns_pkg::MODE_PAL:
                if (addr < prns_pkg::PAL_DEPTH) pal_mem[addr] = data;
            prns_pkg::MODE_TRANS:
                if (addr < prns_pkg::TRANS_BYTES) trans_mem[addr] = data[7:0];
            prns_pkg::MODE_SKIN:
            begin
                skin_mem[addr] = data[7:0];
                skin_wr[addr] = 1;
            end
            default:
            begin
                predict_pixel(col, row, res, ok);
                if (typed)
                begin
                    res.pixel_rgba = t_pix;
                    res.bad_size = t_bad;
                end
                expected_pixels.push_back(res);
            end
        endcase
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            prns_pkg::REG_MAX_SIZE: sh_max = val[12:0];
            prns_pkg::REG_MIP:      sh_mip = val[3:0];
            prns_pkg::REG_SRC_W:    sh_w = val[9:0];
            prns_pkg::REG_SRC_H:    sh_h = val[9:0];
            prns_pkg::REG_TOP:      sh_top = val[3:0];
            prns_pkg::REG_BOTTOM:   sh_bottom = val[3:0];
            default:                sh_class = val[2:0];
        endcase
    endtask

    // random fetch that stays on written source bytes
    task automatic random_fetch();
        logic [8:0] col;
        logic [7:0] row;
        pixel_t     res;
        bit         ok;
        for (int k = 0; k < 40; k++)
        begin
            col = 9'($urandom);
            row = 8'($urandom);
            predict_pixel(col, row, res, ok);
            if (ok)
            begin
                send(prns_pkg::MODE_FETCH, 18'($urandom), $urandom, col, row);
                return;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int     gap;
        bit     v;
        pixel_t got;
        pixel_t want;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && pixels_seen == 40)
            begin
                held = 1;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if ($urandom_range(63) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(15);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                v = out_ch.valid;
                got.pixel_rgba = out_ch.pixel_rgba;
                got.bad_size = out_ch.bad_size;
                @(posedge clk);
            end while (!v);
            pixels_seen++;
            if (expected_pixels.size() == 0)
                report($sformatf("unexpected pixel %h", got.pixel_rgba));
            else
            begin
                want = expected_pixels.pop_front();
                if (got.pixel_rgba !== want.pixel_rgba)
                    report($sformatf("pixel_rgba %h, want %h", got.pixel_rgba,
                                     want.pixel_rgba));
                if (got.bad_size !== want.bad_size)
                    report($sformatf("bad_size %b, want %b", got.bad_size, want.bad_size));
            end
        end
    end

    initial
    begin
        stim_t table_rows [$];
        stim_t s;
        int    area;
        logic [31:0] v;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = prns_pkg::MODE_PAL;
        in_ch.address = '0;
        in_ch.data = '0;
        in_ch.column = '0;
        in_ch.row = '0;
        sh_max = '0; sh_mip = '0; sh_w = 10'd1; sh_h = 10'd1;
        sh_top = '0; sh_bottom = '0; sh_class = 3'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // palette entries reachable from the limited source and translation bytes
        for (int i = 0; i < PAL_LOADED; i++)
            send(prns_pkg::MODE_PAL, 18'(i), $urandom, '0, '0);
        send(prns_pkg::MODE_PAL, 18'd255, $urandom, '0, '0);
        // masks and colour rows of every class block, for the indexes in use
        for (int c = 1; c <= 3; c++)
            for (int k = 1; k <= TRANS_BLOCKS; k++)
                for (int i = 0; i <= IDX_MAX + 1; i++)
                    send(prns_pkg::MODE_TRANS,
                         18'(32'(block_offset(3'(c))) + 256 * k + ((i > IDX_MAX) ? 255 : i)),
                         trans_word(), '0, '0);
        for (int i = 0; i < 16; i++)
            send(prns_pkg::MODE_SKIN, 18'(i), skin_word(), '0, '0);

        // directed table
        s = '{default: '0};
        s.mode = prns_pkg::MODE_PAL; s.address = 18'd255; s.data = 32'hffff_ffff;
        table_rows.push_back(s);
        s.address = 18'd300; s.data = 32'h0;                           table_rows.push_back(s);
        s.mode = prns_pkg::MODE_SKIN; s.address = 18'd0; s.data = 32'habcd_efff;
        table_rows.push_back(s);
        s.address = 18'h3ffff; s.data = 32'h5a;                        table_rows.push_back(s);
        s.mode = prns_pkg::MODE_TRANS; s.address = 18'd16383;          table_rows.push_back(s);
        s.address = 18'h3ffff;                                         table_rows.push_back(s);
        s = '{default: '0};
        s.mode = prns_pkg::MODE_FETCH; s.typed = 1; s.t_pix = 32'hffff_ffff; s.t_bad = 1'b1;
        table_rows.push_back(s);
        s.column = 9'd511; s.row = 8'd255;                             table_rows.push_back(s);
        s = '{default: '0};
        s.is_reg = 1; s.reg_idx = prns_pkg::REG_MIP; s.reg_val = 32'd15;
        table_rows.push_back(s);
        s = '{default: '0};
        s.mode = prns_pkg::MODE_FETCH; s.column = 9'd3; s.typed = 1; s.t_bad = 1'b1;
        table_rows.push_back(s);
        s = '{default: '0};
        s.is_reg = 1; s.reg_idx = prns_pkg::REG_MIP; s.reg_val = 32'd9;
        table_rows.push_back(s);
        s = '{default: '0};
        s.mode = prns_pkg::MODE_FETCH; s.typed = 1; s.t_bad = 1'b1;    table_rows.push_back(s);
        s = '{default: '0};
        s.is_reg = 1; s.reg_idx = prns_pkg::REG_MIP; s.reg_val = 32'd0;
        table_rows.push_back(s);
        s.reg_idx = prns_pkg::REG_MAX_SIZE; s.reg_val = 32'd8191;      table_rows.push_back(s);
        s.reg_idx = prns_pkg::REG_SRC_W; s.reg_val = 32'd0;            table_rows.push_back(s);
        s = '{default: '0};
        s.mode = prns_pkg::MODE_FETCH; s.column = 9'd100; s.row = 8'd7;
        s.typed = 1; s.t_pix = 32'hffff_ffff; s.t_bad = 1'b0;          table_rows.push_back(s);
        s = '{default: '0};
        s.is_reg = 1; s.reg_idx = prns_pkg::REG_SRC_W; s.reg_val = 32'd4;
        table_rows.push_back(s);
        s.reg_idx = prns_pkg::REG_SRC_H; s.reg_val = 32'd4;            table_rows.push_back(s);
        s.reg_idx = prns_pkg::REG_TOP; s.reg_val = 32'd1;              table_rows.push_back(s);
        s.reg_idx = prns_pkg::REG_BOTTOM; s.reg_val = 32'd10;          table_rows.push_back(s);
        s.reg_idx = prns_pkg::REG_CLASS; s.reg_val = 32'd0;            table_rows.push_back(s);
        s = '{default: '0};
        s.mode = prns_pkg::MODE_FETCH; s.column = 9'd511; s.row = 8'd255;
        table_rows.push_back(s);
        s = '{default: '0};
        s.is_reg = 1; s.reg_idx = prns_pkg::REG_CLASS; s.reg_val = 32'd3;
        table_rows.push_back(s);
        s = '{default: '0};
        s.mode = prns_pkg::MODE_FETCH; s.column = 9'd200; s.row = 8'd100;
        table_rows.push_back(s);
        s = '{default: '0};
        s.is_reg = 1; s.reg_idx = prns_pkg::REG_TOP; s.reg_val = 32'd11;
        table_rows.push_back(s);
        s = '{default: '0};
        s.mode = prns_pkg::MODE_FETCH; s.column = 9'd17; s.row = 8'd33;
        table_rows.push_back(s);

        foreach (table_rows[i])
        begin
            if (table_rows[i].is_reg)
            begin
                settle();
                reg_write(table_rows[i].reg_idx, table_rows[i].reg_val);
            end
            else
                send(table_rows[i].mode, table_rows[i].address, table_rows[i].data,
                     table_rows[i].column, table_rows[i].row, table_rows[i].typed,
                     table_rows[i].t_pix, table_rows[i].t_bad);
        end

        // random phases
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case ($urandom_range(3))
                0:       v = 32'd0;
                1:       v = 32'd4096;
                2:       v = $urandom_range(8191);
                default: v = $urandom_range(600);
            endcase
            reg_write(prns_pkg::REG_MAX_SIZE, v);
            reg_write(prns_pkg::REG_MIP, ($urandom_range(5) == 0) ? $urandom_range(15)
                                                                   : $urandom_range(3));
            reg_write(prns_pkg::REG_SRC_W, (ph == NUM_PHASES - 1) ? 32'd1023
                      : ($urandom_range(4) == 0) ? $urandom_range(1023)
                                                 : $urandom_range(1, 16));
            reg_write(prns_pkg::REG_SRC_H, (ph == NUM_PHASES - 1) ? 32'd1023
                      : ($urandom_range(4) == 0) ? $urandom_range(1023)
                                                 : $urandom_range(1, 16));
            reg_write(prns_pkg::REG_TOP, $urandom_range(15));
            reg_write(prns_pkg::REG_BOTTOM, $urandom_range(15));
            reg_write(prns_pkg::REG_CLASS, $urandom_range(7));
            area = sh_w * sh_h;
            if (area <= 1024)
                for (int i = 0; i < area; i++)
                    if (!skin_wr[i] || $urandom_range(7) == 0)
                        send(prns_pkg::MODE_SKIN, 18'(i), skin_word(), 9'($urandom),
                             8'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(9))
                    0:       send(prns_pkg::MODE_PAL, 18'($urandom_range(511)), $urandom,
                                  9'($urandom), 8'($urandom));
                    1:       send(prns_pkg::MODE_TRANS, ($urandom_range(1) == 0)
                                  ? 18'($urandom) : 18'($urandom_range(TRANS_LO, TRANS_HI)),
                                  trans_word(), 9'($urandom), 8'($urandom));
                    2:       send(prns_pkg::MODE_SKIN, ($urandom_range(1) == 0)
                                  ? 18'($urandom) : 18'($urandom_range(area > 0 ? area - 1 : 0)),
                                  skin_word(), 9'($urandom), 8'($urandom));
                    default: random_fetch();
                endcase
            end
        end

        settle();
        if (errors == 0 && expected_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
